[sv/bct_pkg.sv]
// Shared types, constants and helper functions for the box collision table.
// Used by bct_ctrl, bct_datapath and box_collision_table_top; no dependencies.
package bct_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;

  localparam int MASK_W = 36;
  localparam logic [MASK_W-1:0] MASK_RESET = 36'd2181574400;

  localparam int OP_W = 2;
  localparam int SLOT_W = 4;
  localparam int POS_W = 16;
  localparam int SIZE_W = 15;
  localparam int KIND_W = 3;
  localparam int STAT_W = 3;

  localparam logic [KIND_W-1:0] KIND_MAX = 3'd5;
  localparam logic [5:0] KIND_STRIDE = 6'd6;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SET = 2'd2;
  localparam logic [OP_W-1:0] OP_SWEEP = 2'd3;

  localparam logic [STAT_W-1:0] ST_ADDED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 3'd1;
  localparam logic [STAT_W-1:0] ST_DONE = 3'd2;
  localparam logic [STAT_W-1:0] ST_PAIR = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd4;

  localparam logic [2:0] RS_ADD = 3'd0;
  localparam logic [2:0] RS_FULL = 3'd1;
  localparam logic [2:0] RS_EMPTY = 3'd2;
  localparam logic [2:0] RS_DONE = 3'd3;
  localparam logic [2:0] RS_IJ = 3'd4;
  localparam logic [2:0] RS_JI = 3'd5;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } rect_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic listens;
  } attr_t;

  typedef struct packed {
    logic capture;
    logic wr_rect;
    logic wr_attr;
    logic set_valid;
    logic clr_valid;
    logic rd_row;
    logic start_scan;
    logic step;
    logic emit;
    logic [2:0] res_sel;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic slot_ok;
    logic full;
    logic scan_end;
    logic hit_ij;
    logic hit_ji;
    logic out_free;
  } sts_t;

  // Strict overlap: boxes whose edges only touch do not overlap.
  function automatic logic overlap(rect_t a, rect_t b);
    logic signed [POS_W:0] ax;
    logic signed [POS_W:0] ay;
    logic signed [POS_W:0] bx;
    logic signed [POS_W:0] by;
    logic signed [POS_W:0] ax_end;
    logic signed [POS_W:0] ay_end;
    logic signed [POS_W:0] bx_end;
    logic signed [POS_W:0] by_end;
    ax = {a.x[POS_W-1], a.x};
    ay = {a.y[POS_W-1], a.y};
    bx = {b.x[POS_W-1], b.x};
    by = {b.y[POS_W-1], b.y};
    ax_end = ax + $signed({2'b00, a.w});
    ay_end = ay + $signed({2'b00, a.h});
    bx_end = bx + $signed({2'b00, b.w});
    by_end = by + $signed({2'b00, b.h});
    return (bx_end > ax) && (bx < ax_end) && (by_end > ay) && (by < ay_end);
  endfunction

  // Box a is told of box b when a listens and the mask allows the kind pair.
  function automatic logic told(logic [MASK_W-1:0] mask, attr_t a, attr_t b);
    logic [5:0] bit_idx;
    bit_idx = 6'(a.kind) * KIND_STRIDE + 6'(b.kind);
    if (a.kind > KIND_MAX || b.kind > KIND_MAX || !a.listens) begin
      return 1'b0;
    end
    return mask[bit_idx];
  endfunction

endpackage

[sv/bct_ctrl.sv]
// Controller state machine for the box collision table.
// Depends on bct_pkg; drives bct_datapath through command and status structs.
module bct_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  bct_pkg::sts_t sts,
  output bct_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_LOADI = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_PAIR2 = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.op)
          bct_pkg::OP_ADD: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              if (sts.full) begin
                cmd.res_sel = bct_pkg::RS_FULL;
              end else begin
                cmd.res_sel = bct_pkg::RS_ADD;
                cmd.wr_rect = 1'b1;
                cmd.wr_attr = 1'b1;
                cmd.set_valid = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end
          bct_pkg::OP_REMOVE, bct_pkg::OP_SET: begin
            if (sts.out_free) begin
              cmd.emit = 1'b1;
              if (!sts.slot_ok) begin
                cmd.res_sel = bct_pkg::RS_EMPTY;
              end else begin
                cmd.res_sel = bct_pkg::RS_DONE;
                cmd.clr_valid = (sts.op == bct_pkg::OP_REMOVE);
                cmd.wr_rect = (sts.op == bct_pkg::OP_SET);
              end
              state_nxt = S_IDLE;
            end
          end
          default: begin
            if (!sts.slot_ok) begin
              if (sts.out_free) begin
                cmd.emit = 1'b1;
                cmd.res_sel = bct_pkg::RS_EMPTY;
                state_nxt = S_IDLE;
              end
            end else begin
              cmd.rd_row = 1'b1;
              state_nxt = S_LOADI;
            end
          end
        endcase
      end
      S_LOADI: begin
        cmd.start_scan = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_end) begin
          state_nxt = S_DONE;
        end else if (sts.hit_ij) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            cmd.res_sel = bct_pkg::RS_IJ;
            if (sts.hit_ji) begin
              state_nxt = S_PAIR2;
            end else begin
              cmd.step = 1'b1;
            end
          end
        end else if (sts.hit_ji) begin
          if (sts.out_free) begin
            cmd.emit = 1'b1;
            cmd.res_sel = bct_pkg::RS_JI;
            cmd.step = 1'b1;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_PAIR2: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.res_sel = bct_pkg::RS_JI;
          cmd.step = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.res_sel = bct_pkg::RS_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/bct_datapath.sv]
// Datapath of the box collision table: box memories, valid bits, pair mask,
// scan counter, overlap test and result register. Depends on bct_pkg.
module bct_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bct_pkg::cmd_t                      cmd,
  output bct_pkg::sts_t                      sts,
  input  logic [bct_pkg::OP_W-1:0]           in_operation,
  input  logic [bct_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [bct_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [bct_pkg::POS_W-1:0]   in_pos_y,
  input  logic [bct_pkg::SIZE_W-1:0]         in_size_w,
  input  logic [bct_pkg::SIZE_W-1:0]         in_size_h,
  input  logic [bct_pkg::KIND_W-1:0]         in_kind,
  input  logic                               in_listens,
  input  logic                               cfg_wr_en,
  input  logic [bct_pkg::MASK_W-1:0]         cfg_wr_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bct_pkg::STAT_W-1:0]         out_status,
  output logic [bct_pkg::SLOT_W-1:0]         out_self_slot,
  output logic [bct_pkg::SLOT_W-1:0]         out_other_slot,
  output logic                               out_last
);

  bct_pkg::rect_t rect_mem [bct_pkg::SLOTS];
  bct_pkg::attr_t attr_mem [bct_pkg::SLOTS];

  logic [bct_pkg::SLOTS-1:0] valid_r;
  logic [bct_pkg::SLOTS-1:0] valid_nxt;
  logic [bct_pkg::MASK_W-1:0] mask_r;

  logic [bct_pkg::OP_W-1:0] req_op_r;
  logic [bct_pkg::SLOT_W-1:0] req_slot_r;
  bct_pkg::rect_t req_rect_r;
  bct_pkg::attr_t req_attr_r;

  bct_pkg::rect_t rd_rect_r;
  bct_pkg::attr_t rd_attr_r;
  bct_pkg::rect_t row_rect_r;
  bct_pkg::attr_t row_attr_r;

  logic [bct_pkg::CNT_W-1:0] j_r;
  logic [bct_pkg::CNT_W-1:0] j_nxt;

  logic [bct_pkg::IDX_W-1:0] req_idx;
  logic [bct_pkg::IDX_W-1:0] free_idx;
  logic [bct_pkg::IDX_W-1:0] wr_addr;
  logic [bct_pkg::IDX_W-1:0] rd_addr;
  logic [bct_pkg::IDX_W-1:0] j_idx;
  logic rd_en;
  logic ovl;

  logic out_valid_r;
  logic [bct_pkg::STAT_W-1:0] out_status_r;
  logic [bct_pkg::SLOT_W-1:0] out_self_r;
  logic [bct_pkg::SLOT_W-1:0] out_other_r;
  logic out_last_r;
  logic [bct_pkg::STAT_W-1:0] res_status;
  logic [bct_pkg::SLOT_W-1:0] res_self;
  logic [bct_pkg::SLOT_W-1:0] res_other;
  logic res_last;

  assign req_idx = bct_pkg::IDX_W'(req_slot_r);
  assign j_idx = j_r[bct_pkg::IDX_W-1:0];

  always_comb begin
    free_idx = '0;
    for (int i = bct_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = bct_pkg::IDX_W'(i);
      end
    end
  end

  assign wr_addr = (req_op_r == bct_pkg::OP_ADD) ? free_idx : req_idx;

  always_comb begin
    rd_addr = req_idx;
    j_nxt = j_r;
    if (cmd.start_scan) begin
      j_nxt = bct_pkg::CNT_W'(req_idx) + 1'b1;
      rd_addr = j_nxt[bct_pkg::IDX_W-1:0];
    end else if (cmd.step) begin
      j_nxt = j_r + 1'b1;
      rd_addr = j_nxt[bct_pkg::IDX_W-1:0];
    end
  end

  assign rd_en = cmd.rd_row | cmd.start_scan | cmd.step;

  always_ff @(posedge clk) begin
    if (cmd.wr_rect) begin
      rect_mem[wr_addr] <= req_rect_r;
    end
    if (cmd.wr_attr) begin
      attr_mem[wr_addr] <= req_attr_r;
    end
    if (rd_en) begin
      rd_rect_r <= rect_mem[rd_addr];
      rd_attr_r <= attr_mem[rd_addr];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.set_valid) begin
      valid_nxt[wr_addr] = 1'b1;
    end
    if (cmd.clr_valid) begin
      valid_nxt[wr_addr] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      mask_r <= bct_pkg::MASK_RESET;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op_r <= in_operation;
      req_slot_r <= in_slot;
      req_rect_r <= '{x: in_pos_x, y: in_pos_y, w: in_size_w, h: in_size_h};
      req_attr_r <= '{kind: in_kind, listens: in_listens};
    end
    if (cmd.start_scan) begin
      row_rect_r <= rd_rect_r;
      row_attr_r <= rd_attr_r;
    end
    j_r <= j_nxt;
  end

  assign ovl = bct_pkg::overlap(row_rect_r, rd_rect_r);

  always_comb begin
    sts.op = req_op_r;
    sts.slot_ok = (32'(req_slot_r) < bct_pkg::SLOTS) && valid_r[req_idx];
    sts.full = &valid_r;
    sts.scan_end = (32'(j_r) >= bct_pkg::SLOTS);
    sts.hit_ij = valid_r[j_idx] && ovl && bct_pkg::told(mask_r, row_attr_r, rd_attr_r);
    sts.hit_ji = valid_r[j_idx] && ovl && bct_pkg::told(mask_r, rd_attr_r, row_attr_r);
    sts.out_free = !out_valid_r || !out_stall;
  end

  always_comb begin
    res_status = bct_pkg::ST_DONE;
    res_self = req_slot_r;
    res_other = '0;
    res_last = 1'b1;
    case (cmd.res_sel)
      bct_pkg::RS_ADD: begin
        res_status = bct_pkg::ST_ADDED;
        res_self = bct_pkg::SLOT_W'(free_idx);
      end
      bct_pkg::RS_FULL: begin
        res_status = bct_pkg::ST_FULL;
        res_self = '0;
      end
      bct_pkg::RS_EMPTY: begin
        res_status = bct_pkg::ST_EMPTY;
      end
      bct_pkg::RS_IJ: begin
        res_status = bct_pkg::ST_PAIR;
        res_self = bct_pkg::SLOT_W'(req_idx);
        res_other = bct_pkg::SLOT_W'(j_idx);
        res_last = 1'b0;
      end
      bct_pkg::RS_JI: begin
        res_status = bct_pkg::ST_PAIR;
        res_self = bct_pkg::SLOT_W'(j_idx);
        res_other = bct_pkg::SLOT_W'(req_idx);
        res_last = 1'b0;
      end
      default: begin
        res_status = bct_pkg::ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit | (out_valid_r & out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= res_status;
      out_self_r <= res_self;
      out_other_r <= res_other;
      out_last_r <= res_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_self_slot = out_self_r;
  assign out_other_slot = out_other_r;
  assign out_last = out_last_r;

endmodule

[sv/box_collision_table_top.sv]
// Add, remove and set rectangle give one result: the request is captured, then the execute state
// registers the result once the result register is free. Sweeping row i compares the later slots
// one by one through the single box memory read port; a slot that yields two pairs emits both.
// One request is in work at a time; the result register lets the next one be taken early.
// Reset clears the valid bits and loads the default pair mask; box contents stay undefined.
module box_collision_table_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bct_pkg::OP_W-1:0]           in_operation,
  input  logic [bct_pkg::SLOT_W-1:0]         in_slot,
  input  logic signed [bct_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [bct_pkg::POS_W-1:0]   in_pos_y,
  input  logic [bct_pkg::SIZE_W-1:0]         in_size_w,
  input  logic [bct_pkg::SIZE_W-1:0]         in_size_h,
  input  logic [bct_pkg::KIND_W-1:0]         in_kind,
  input  logic                               in_listens,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bct_pkg::STAT_W-1:0]         out_status,
  output logic [bct_pkg::SLOT_W-1:0]         out_self_slot,
  output logic [bct_pkg::SLOT_W-1:0]         out_other_slot,
  output logic                               out_last,
  input  logic                               cfg_wr_en,
  input  logic [bct_pkg::MASK_W-1:0]         cfg_wr_data
);

  bct_pkg::cmd_t cmd;
  bct_pkg::sts_t sts;

  bct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  bct_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_operation),
    .in_slot        (in_slot),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_size_w      (in_size_w),
    .in_size_h      (in_size_h),
    .in_kind        (in_kind),
    .in_listens     (in_listens),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_self_slot  (out_self_slot),
    .out_other_slot (out_other_slot),
    .out_last       (out_last)
  );

endmodule
